### rtl/double_ended_queue_unit_assert.svh
// ------------------------------------------------------------------------
// double-ended queue assertion macros
// shared property forms for the queue checker
// ------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/deq_pkg.sv
// ------------------------------------------------------------------------
// deq_pkg
// types and constants shared by the double-ended queue modules
// ------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // fixed field widths of the stream words
  localparam int OPCODE_W = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int EXT_W    = 64;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PEEK_BACK  = 3'd2,
    OP_PEEK_FRONT = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_POP_FRONT  = 3'd5,
    OP_CLEAR      = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

### rtl/double_ended_queue_unit.sv
// ------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue on a ring buffer, one result word per command
// ------------------------------------------------------------------------
// Each input word carries an opcode and a data word: push at the back or
// front, peek or pop at the back or front, or clear. Every command returns
// exactly one result word with the element read (zero when none), a status
// (done, empty, or full with the push refused), the occupancy after the
// command and an empty flag. Commands are handled one at a time: the word
// is captured in the cycle it is accepted, the next cycle executes it
// (pointer and count update plus the registered ring memory read), and the
// result word is valid from the cycle after that. The result holds while
// the result side stalls, and the next command is taken the cycle after
// the result is consumed, so no new command enters while one is in work.
// The sequencer steps through the idle (capture), execute and result states.
// The queue holds up to DEPTH elements of DATA_WIDTH bits; only the low
// DATA_WIDTH bits of data_in are stored, and the occupancy field shows the
// low 5 bits of the count. Clear resets the pointers and the count only;
// stored words remain but are never read.
// ------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // command stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] opcode, [34:3] data_in, [39:35] zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] data_out, [33:32] status, [38:34] occupancy, [39] is_empty
  output logic [deq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  deq_pkg::dp_cmd_t cmd;

  logic [deq_pkg::WORD_W-1:0]   data_out;
  logic [deq_pkg::STATUS_W-1:0] status;
  logic [deq_pkg::OCC_W-1:0]    occupancy;
  logic                         is_empty;

  // sequencer
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // ring buffer and pointers
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (s_axis_tdata[2:0]),
    .data_in   (s_axis_tdata[34:3]),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy),
    .is_empty  (is_empty)
  );

  // result word packing, highest field first
  assign m_axis_tdata = {is_empty, occupancy, status, data_out};

endmodule

### rtl/deq_ctrl.sv
// ------------------------------------------------------------------------
// deq_ctrl
// sequencer: take a word, run it on the datapath, hold the result
// ------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::dp_cmd_t  cmd
);

  deq_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      deq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = deq_pkg::ST_RESULT;
      end
      deq_pkg::ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/deq_datapath.sv
// ------------------------------------------------------------------------
// deq_datapath
// ring buffer memory, end pointers, element count and result registers
// ------------------------------------------------------------------------
module deq_datapath #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::dp_cmd_t                cmd,
  input  logic [deq_pkg::OPCODE_W-1:0]    opcode,
  input  logic [deq_pkg::WORD_W-1:0]      data_in,
  output logic [deq_pkg::WORD_W-1:0]      data_out,
  output logic [deq_pkg::STATUS_W-1:0]    status,
  output logic [deq_pkg::OCC_W-1:0]       occupancy,
  output logic                            is_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  deq_pkg::opcode_t      op;
  logic [DATA_WIDTH-1:0] word;
  logic [IDX_W-1:0]      front, front_next, back, back_next;
  logic [CNT_W-1:0]      count, count_next;
  deq_pkg::status_t      sts, sts_next;
  logic                  has_data, has_data_next;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  empty, full;
  logic [deq_pkg::EXT_W-1:0] in_ext, out_ext;
  logic [31:0]               occ_ext;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_SLOT : i - 1'b1;
  endfunction

  assign in_ext = deq_pkg::EXT_W'(data_in);

  // payload capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= deq_pkg::opcode_t'(opcode);
      word <= in_ext[DATA_WIDTH-1:0];
    end
  end

  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);

  always_comb begin
    front_next    = front;
    back_next     = back;
    count_next    = count;
    sts_next      = deq_pkg::STS_DONE;
    has_data_next = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = back;
    rd_addr       = front;
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          sts_next = deq_pkg::STS_FULL;
        end else begin
          wr_en      = 1'b1;
          back_next  = slot_inc(back);
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          sts_next = deq_pkg::STS_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = slot_dec(front);
          front_next = slot_dec(front);
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PEEK_BACK, deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          sts_next = deq_pkg::STS_EMPTY;
        end else begin
          rd_addr       = slot_dec(back);
          has_data_next = 1'b1;
          if (op == deq_pkg::OP_POP_BACK) begin
            back_next  = slot_dec(back);
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          sts_next = deq_pkg::STS_EMPTY;
        end else begin
          has_data_next = 1'b1;
          if (op == deq_pkg::OP_POP_FRONT) begin
            front_next = slot_inc(front);
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_next = '0;
        back_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  // element memory, at most one write plus one registered read per operation
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[wr_addr] <= word;
    end
    if (cmd.execute) begin
      rd_data  <= mem[rd_addr];
      sts      <= sts_next;
      has_data <= has_data_next;
    end
  end

  assign out_ext   = has_data ? deq_pkg::EXT_W'(rd_data) : '0;
  assign data_out  = out_ext[deq_pkg::WORD_W-1:0];
  assign status    = sts;
  assign occ_ext   = 32'(count);
  assign occupancy = occ_ext[deq_pkg::OCC_W-1:0];
  assign is_empty  = empty;

endmodule

### rtl/deq_checker.sv
// ------------------------------------------------------------------------
// deq_checker
// port-level checks on the double-ended queue
// ------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [deq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [deq_pkg::WORD_W-1:0]   chk_data;
  logic [deq_pkg::STATUS_W-1:0] chk_status;
  logic [deq_pkg::OCC_W-1:0]    chk_occ;
  logic                         chk_empty;
  logic                         in_seen;

  assign chk_data   = m_axis_tdata[31:0];
  assign chk_status = m_axis_tdata[33:32];
  assign chk_occ    = m_axis_tdata[38:34];
  assign chk_empty  = m_axis_tdata[39];
  assign in_seen    = s_axis_tvalid && (s_axis_tdata[39:35] == '0);

  // no new command while a result word is waiting
  `DEQ_ASSERT_IMP(a_one_at_a_time, clk, rst, m_axis_tvalid, !s_axis_tready, "command taken while result pending")

  // empty flag agrees with occupancy
  `DEQ_ASSERT_IMP(a_empty_occ, clk, rst, m_axis_tvalid && chk_empty, chk_occ == '0, "empty flag with nonzero occupancy")

  // no data on an empty or refused command
  `DEQ_ASSERT_IMP(a_no_data, clk, rst, m_axis_tvalid && (chk_status == deq_pkg::STS_EMPTY || chk_status == deq_pkg::STS_FULL), chk_data == '0, "data on failed command")

  // occupancy never beyond capacity
  `DEQ_ASSERT_IMP(a_occ_bound, clk, rst, m_axis_tvalid && (DEPTH < 32) && !in_seen, 32'(chk_occ) <= 32'(DEPTH), "occupancy above depth")

  // a stalled result word holds
  `DEQ_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed under stall")

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top
// self-checking bench for the double-ended queue unit
// ------------------------------------------------------------------------
// Command words go in on the slave stream and result words are checked
// as they come out of the master stream. A queue model in the bench
// tracks the ring contents, both end pointers and the fill count, and
// predicts one result word per accepted command. Directed tests cover
// the empty and full cases, wrap of the front pointer, clear and the unused
// opcode. Random tests then swing the fill level between empty and full
// under random stalls on both sides, with one run at full rate and one
// where the sender waits for all results after each batch of commands.
// ------------------------------------------------------------------------
module tb_top;

  localparam int QUEUE_DEPTH = deq_pkg::DEPTH_DEFAULT;
  localparam int IDLE_PCT    = 21;
  // opcode 7 has no enum member; the unit treats it as a no-op
  localparam logic [deq_pkg::OPCODE_W-1:0] OP_RESERVED = 3'd7;

  // result word as it sits on m_axis_tdata, msb first
  typedef struct packed {
    logic                      is_empty;
    logic [deq_pkg::OCC_W-1:0] occupancy;
    deq_pkg::status_t          status;
    logic [deq_pkg::WORD_W-1:0] data_out;
  } deq_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [deq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // no idling on either side while set
  bit steady = 1'b0;
  int mismatches = 0;
  deq_result_t pending_replies[$];

  // queue model state
  logic [deq_pkg::WORD_W-1:0] ring [QUEUE_DEPTH];
  int head = 0;
  int tail = 0;
  int fill = 0;

  double_ended_queue_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // runs one command on the queue model and returns its result word
  function automatic deq_result_t apply_cmd(logic [deq_pkg::OPCODE_W-1:0] op,
                                            logic [deq_pkg::WORD_W-1:0] word);
    deq_result_t r;
    r.data_out = '0;
    r.status   = deq_pkg::STS_DONE;
    case (op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = deq_pkg::STS_FULL;
        end else if (op == deq_pkg::OP_PUSH_BACK) begin
          ring[tail] = word;
          tail = (tail + 1) % QUEUE_DEPTH;
          fill++;
        end else begin
          head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          ring[head] = word;
          fill++;
        end
      end
      deq_pkg::OP_PEEK_BACK, deq_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          r.status = deq_pkg::STS_EMPTY;
        end else begin
          r.data_out = ring[(tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          if (op == deq_pkg::OP_POP_BACK) begin
            tail = (tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            fill--;
          end
        end
      end
      deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_POP_FRONT: begin
        if (fill == 0) begin
          r.status = deq_pkg::STS_EMPTY;
        end else begin
          r.data_out = ring[head];
          if (op == deq_pkg::OP_POP_FRONT) begin
            head = (head + 1) % QUEUE_DEPTH;
            fill--;
          end
        end
      end
      deq_pkg::OP_CLEAR: begin
        head = 0;
        tail = 0;
        fill = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = fill[deq_pkg::OCC_W-1:0];
    r.is_empty  = (fill == 0);
    return r;
  endfunction

  // sends one command word; tvalid stays high afterwards so the next
  // word can follow without a bubble
  task automatic send_cmd(input logic [deq_pkg::OPCODE_W-1:0] op,
                          input logic [deq_pkg::WORD_W-1:0] word);
    deq_result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(deq_pkg::IN_TDATA_W - deq_pkg::WORD_W - deq_pkg::OPCODE_W){1'b0}},
                      word, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_cmd(op, word);
    pending_replies.push_back(predicted);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [deq_pkg::OPCODE_W-1:0] pick_op(int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 1) return OP_RESERVED;
    if (roll < 3) return deq_pkg::OP_CLEAR;
    if (roll < push_pct) begin
      return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    end
    case ($urandom_range(3))
      0:       return deq_pkg::OP_PEEK_BACK;
      1:       return deq_pkg::OP_PEEK_FRONT;
      2:       return deq_pkg::OP_POP_BACK;
      default: return deq_pkg::OP_POP_FRONT;
    endcase
  endfunction

  function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // peek and pop on an empty queue, plus the no-op opcode
  task automatic test_empty_queue();
    send_cmd(deq_pkg::OP_PEEK_BACK, 32'h1234_5678);
    send_cmd(deq_pkg::OP_POP_FRONT, '1);
    send_cmd(OP_RESERVED, '1);
  endtask

  // fill from both ends past the wrap point, refuse pushes when full,
  // then read both ends and clear
  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_cmd(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
               (i == 0) ? '0 : (i == 1) ? '1 : $urandom());
    end
    send_cmd(deq_pkg::OP_PUSH_BACK, 32'hdead_beef);
    send_cmd(deq_pkg::OP_PUSH_FRONT, 32'h5555_aaaa);
    send_cmd(deq_pkg::OP_PEEK_BACK, '0);
    send_cmd(deq_pkg::OP_PEEK_FRONT, '0);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    send_cmd(deq_pkg::OP_POP_FRONT, '0);
    send_cmd(deq_pkg::OP_CLEAR, '1);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
  endtask

  // alternate push-heavy and pop-heavy stretches so the fill level
  // keeps running into both limits
  task automatic test_random_mix();
    int push_pct;
    for (int chunk = 0; chunk < 7; chunk++) begin
      push_pct = (chunk % 2 == 0) ? 80 : 30;
      for (int n = 0; n < 50; n++) send_cmd(pick_op(push_pct), pick_word());
    end
  endtask

  // long stretch at full rate on both sides
  task automatic test_back_to_back();
    steady = 1'b1;
    for (int n = 0; n < 120; n++) send_cmd(pick_op(55), pick_word());
    steady = 1'b0;
  endtask

  // sender waits for all outstanding results after each batch of commands
  task automatic test_paused_sender();
    for (int round = 0; round < 3; round++) begin
      for (int n = 0; n < 10; n++) send_cmd(pick_op(60), pick_word());
      hold_until_drained();
    end
  endtask

  // result side stalls at random except during the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_checker
    deq_result_t seen;
    deq_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = deq_result_t'(m_axis_tdata);
      if (pending_replies.size() == 0) begin
        $error("result word 0x%010h with no command outstanding", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (seen.data_out !== want.data_out) begin
          $error("data_out: expected 0x%08h, got 0x%08h", want.data_out, seen.data_out);
          mismatches++;
        end
        if (seen.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, seen.status);
          mismatches++;
        end
        if (seen.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, seen.occupancy);
          mismatches++;
        end
        if (seen.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, seen.is_empty);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_full_queue();
    test_random_mix();
    test_back_to_back();
    test_paused_sender();
    hold_until_drained();
    // let any stray word show up
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("[double_ended_queue_unit] OK");
    end else begin
      $display("[double_ended_queue_unit] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest passing run
  initial begin
    #2_000_000;
    $display("[double_ended_queue_unit] ERROR");
    $finish;
  end

endmodule

### double_ended_queue_unit.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
tb/tb_top.sv
